// ===== rtl/particle_type_energy_histogram_macros.svh =====
// Assertion helpers for the particle histogram. Each check is clocked on clk
// and is switched off while rst_n is low.
`ifndef PARTICLE_TYPE_ENERGY_HISTOGRAM_MACROS_SVH
`define PARTICLE_TYPE_ENERGY_HISTOGRAM_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define PTEH_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("histogram check failed");

// The consequent must hold in the cycle after the antecedent.
`define PTEH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("histogram check failed");

`else

`define PTEH_ASSERT_SAME(lbl, ante, cons)
`define PTEH_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/pteh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pteh_pkg;

    // Field widths: bin count, bin energy sum, bin index and particle class.
    localparam int COUNT_W  = 32;
    localparam int ENERGY_W = 48;
    localparam int BIN_W    = 6;
    localparam int CLASS_W  = 4;

    // Table geometry: three regions of eleven classes per scoring volume.
    localparam int NUM_CLASSES         = 11;
    localparam int BINS_PER_VOLUME     = 3 * NUM_CLASSES;
    localparam int DEFAULT_NUM_VOLUMES = 1;

    localparam logic [31:0] THRESHOLD_RESET = 32'd20000;

    // First bin of the low and the high energy region.
    localparam logic [BIN_W-1:0] REGION_LOW_BASE  = 6'd11;
    localparam logic [BIN_W-1:0] REGION_HIGH_BASE = 6'd22;

    // Command codes.
    localparam logic [1:0] CMD_RECORD = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Particle classes.
    localparam logic [CLASS_W-1:0] CLASS_NONE         = 4'd0;
    localparam logic [CLASS_W-1:0] CLASS_ELECTRON     = 4'd1;
    localparam logic [CLASS_W-1:0] CLASS_GAMMA        = 4'd2;
    localparam logic [CLASS_W-1:0] CLASS_MUON         = 4'd3;
    localparam logic [CLASS_W-1:0] CLASS_NEUTRINO     = 4'd4;
    localparam logic [CLASS_W-1:0] CLASS_PION         = 4'd5;
    localparam logic [CLASS_W-1:0] CLASS_NEUTRON      = 4'd6;
    localparam logic [CLASS_W-1:0] CLASS_PROTON       = 4'd7;
    localparam logic [CLASS_W-1:0] CLASS_ION          = 4'd8;
    localparam logic [CLASS_W-1:0] CLASS_OTHER_MESON  = 4'd9;
    localparam logic [CLASS_W-1:0] CLASS_OTHER_BARYON = 4'd10;

    // Particle type magnitudes that pick a named class, and the meson/baryon boundary.
    localparam logic [31:0] PDG_ELECTRON  = 32'd11;
    localparam logic [31:0] PDG_NU_E      = 32'd12;
    localparam logic [31:0] PDG_MUON      = 32'd13;
    localparam logic [31:0] PDG_NU_MU     = 32'd14;
    localparam logic [31:0] PDG_NU_TAU    = 32'd16;
    localparam logic [31:0] PDG_GAMMA     = 32'd22;
    localparam logic [31:0] PDG_PI_ZERO   = 32'd111;
    localparam logic [31:0] PDG_PI_PLUS   = 32'd211;
    localparam logic [31:0] PDG_BOUNDARY  = 32'd1000;
    localparam logic [31:0] PDG_NEUTRON   = 32'd2112;
    localparam logic [31:0] PDG_PROTON    = 32'd2212;

    // Last step of a record sequence: four reads, each write in the cycle after its read.
    localparam logic [2:0] REC_LAST_STEP = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REC,
        ST_RD_OUT
    } state_t;

    // Class of a particle from the magnitude of its type code.
    function automatic logic [CLASS_W-1:0] classify(input logic [31:0] mag,
                                                    input logic ion);
        logic [CLASS_W-1:0] cls;
        begin
            if (mag == PDG_ELECTRON)
                cls = CLASS_ELECTRON;
            else if (mag == PDG_GAMMA)
                cls = CLASS_GAMMA;
            else if (mag == PDG_MUON)
                cls = CLASS_MUON;
            else if (mag == PDG_NU_E || mag == PDG_NU_MU || mag == PDG_NU_TAU)
                cls = CLASS_NEUTRINO;
            else if (mag == PDG_PI_ZERO || mag == PDG_PI_PLUS)
                cls = CLASS_PION;
            else if (mag == PDG_NEUTRON)
                cls = CLASS_NEUTRON;
            else if (mag == PDG_PROTON)
                cls = CLASS_PROTON;
            else if (ion)
                cls = CLASS_ION;
            else if (mag < PDG_BOUNDARY)
                cls = CLASS_OTHER_MESON;
            else if (mag > PDG_BOUNDARY)
                cls = CLASS_OTHER_BARYON;
            else
                cls = CLASS_NONE;
            return cls;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/particle_type_energy_histogram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Particle type and energy histogram. Each input word carries a command in
// s_tuser: a qualifying record adds one count and the kinetic energy to four
// bins (class by region, all by region, class by any region, all by any
// region; the two class bins are left out for class none), a read returns one
// bin's count and energy sum on the m side, and a clear empties every bin.
// Both sums saturate. The bins live in one 80-bit RAM with a registered read
// port, so a record is up to four read-modify-write passes, one read per cycle
// with each write in the cycle after its read. s_tready stays low while a
// record runs and while a read waits for the output register to drain; a
// clear, an unqualified record or an unused command is done on acceptance.
// A clear acts at once through a valid bit per entry; there is no clearing pass.
// The threshold register may be written only while the block is idle.
module particle_type_energy_histogram
    import pteh_pkg::*;
#(
    parameter int NUM_VOLUMES = DEFAULT_NUM_VOLUMES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Threshold register write port.
    input  wire logic        energy_threshold_we,
    input  wire logic [31:0] energy_threshold_wdata,
    // Input words.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pdg_code[31:0], is_ion[32], kinetic_energy[64:33], bin_index[70:65], zero pad.
    input  wire logic [71:0] s_tdata,
    // cmd[1:0], qualifies[2].
    input  wire logic [2:0]  s_tuser,
    // Result words.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // bin_count[31:0], bin_energy_sum[79:32].
    output logic [79:0]      m_tdata
);

`include "particle_type_energy_histogram_macros.svh"

    localparam int DEPTH  = NUM_VOLUMES * BINS_PER_VOLUME;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int RAM_W  = COUNT_W + ENERGY_W;

    // Input field unpacking.
    logic [1:0]       cmd_in;
    logic             qualifies_in;
    logic [31:0]      pdg_in;
    logic             is_ion_in;
    logic [31:0]      energy_in;
    logic [BIN_W-1:0] bin_in;

    assign cmd_in       = s_tuser[1:0];
    assign qualifies_in = s_tuser[2];
    assign pdg_in       = s_tdata[31:0];
    assign is_ion_in    = s_tdata[32];
    assign energy_in    = s_tdata[64:33];
    assign bin_in       = s_tdata[70:65];

    state_t              state_reg, state_next;
    logic [2:0]          step_reg, step_next;
    logic [CLASS_W-1:0]  cls_reg;
    logic                high_reg;
    logic [31:0]         energy_reg;
    logic [31:0]         threshold_reg;
    logic [DEPTH-1:0]    valid_reg;
    logic                wr_en_reg, wr_en_next;
    logic [ADDR_W-1:0]   wr_addr_reg, wr_addr_next;
    logic                rd_known_reg, rd_known_next;
    logic                out_valid_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [ENERGY_W-1:0] out_energy_reg;

    logic                in_acc;
    logic                out_free;
    logic [31:0]         pdg_mag;
    logic [CLASS_W-1:0]  cls_in;
    logic                bin_in_range;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [RAM_W-1:0]    rd_data;
    logic [RAM_W-1:0]    wr_data;
    logic [BIN_W-1:0]    region_base;
    logic [BIN_W-1:0]    rec_bin;
    logic                rec_en;
    logic                load_out;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid & s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Classification and range check of an incoming word.
    assign pdg_mag      = pdg_in[31] ? (32'd0 - pdg_in) : pdg_in;
    assign cls_in       = classify(pdg_mag, is_ion_in);
    assign bin_in_range = ((ADDR_W + 1)'(bin_in) < (ADDR_W + 1)'(DEPTH));

    // Bin of the current record step.
    assign region_base = high_reg ? REGION_HIGH_BASE : REGION_LOW_BASE;

    always_comb
    begin
        rec_bin = '0;
        rec_en  = 1'b0;
        unique case (step_reg)
            3'd0:
            begin
                rec_bin = region_base + BIN_W'(cls_reg);
                rec_en  = (cls_reg != CLASS_NONE);
            end
            3'd1:
            begin
                rec_bin = region_base;
                rec_en  = 1'b1;
            end
            3'd2:
            begin
                rec_bin = BIN_W'(cls_reg);
                rec_en  = (cls_reg != CLASS_NONE);
            end
            3'd3:
            begin
                rec_bin = '0;
                rec_en  = 1'b1;
            end
            default:
            begin
                rec_bin = '0;
                rec_en  = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && cmd_in == CMD_RECORD && qualifies_in)
                    state_next = ST_REC;
                else if (in_acc && cmd_in == CMD_READ)
                    state_next = ST_RD_OUT;
            end
            ST_REC:
            begin
                if (step_reg == REC_LAST_STEP)
                    state_next = ST_IDLE;
            end
            ST_RD_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: RAM read requests and the write pipeline.
    always_comb
    begin
        step_next     = '0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        rd_known_next = rd_known_reg;
        wr_en_next    = 1'b0;
        wr_addr_next  = wr_addr_reg;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && cmd_in == CMD_READ)
                begin
                    rd_en         = bin_in_range;
                    rd_addr       = ADDR_W'(bin_in);
                    rd_known_next = bin_in_range ? valid_reg[ADDR_W'(bin_in)] : 1'b0;
                end
            end
            ST_REC:
            begin
                step_next     = step_reg + 3'd1;
                rd_en         = rec_en;
                rd_addr       = ADDR_W'(rec_bin);
                rd_known_next = valid_reg[ADDR_W'(rec_bin)];
                wr_en_next    = rec_en;
                wr_addr_next  = ADDR_W'(rec_bin);
            end
            ST_RD_OUT:
            begin
                load_out = out_free;
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    // Saturating update of the bin read in the previous cycle.
    logic [COUNT_W-1:0]  old_count;
    logic [ENERGY_W-1:0] old_energy;
    logic [ENERGY_W:0]   energy_sum;
    logic [COUNT_W-1:0]  new_count;
    logic [ENERGY_W-1:0] new_energy;

    assign old_count  = rd_known_reg ? rd_data[COUNT_W-1:0] : '0;
    assign old_energy = rd_known_reg ? rd_data[RAM_W-1:COUNT_W] : '0;
    assign energy_sum = {1'b0, old_energy} + (ENERGY_W + 1)'(energy_reg);
    assign new_count  = (&old_count) ? old_count : old_count + COUNT_W'(1);
    assign new_energy = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];
    assign wr_data    = {new_energy, new_count};

    pteh_ram #(
        .WIDTH (RAM_W),
        .DEPTH (DEPTH)
    ) u_bins (
        .clk     (clk),
        .we      (wr_en_reg),
        .wr_addr (wr_addr_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            wr_en_reg    <= 1'b0;
            rd_known_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            wr_en_reg    <= wr_en_next;
            rd_known_reg <= rd_known_next;
        end
    end

    // Write address, registered so that it follows its read in the next cycle.
    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
    end

    // Record payload, captured on acceptance.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cls_reg    <= cls_in;
            high_reg   <= !(energy_in < threshold_reg);
            energy_reg <= energy_in;
        end
    end

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= THRESHOLD_RESET;
        else if (energy_threshold_we)
            threshold_reg <= energy_threshold_wdata;
    end

    // Valid bit per entry: an entry that is not valid reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (in_acc && cmd_in == CMD_CLEAR)
            valid_reg <= '0;
        else if (wr_en_reg)
            valid_reg[wr_addr_reg] <= 1'b1;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_count_reg  <= old_count;
            out_energy_reg <= old_energy;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_energy_reg, out_count_reg};

    // Checks.
    `PTEH_ASSERT_SAME(a_write_only_in_record, wr_en_reg, state_reg == ST_REC)
    `PTEH_ASSERT_NEXT(a_clear_empties, in_acc && cmd_in == CMD_CLEAR, valid_reg == '0)
    `PTEH_ASSERT_SAME(a_result_after_read, $rose(out_valid_reg), $past(state_reg) == ST_RD_OUT)

endmodule

`default_nettype wire

// ===== rtl/pteh_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module pteh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
